// ===== rtl/fbba_pkg.sv =====
package fbba_pkg;

  localparam int NUM_BLOCKS    = 1024;
  localparam int MAP_WORD_BITS = 32;
  localparam int MAP_WORDS     = (NUM_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int WORD_IDX_W    = $clog2(MAP_WORDS);
  localparam int BIT_IDX_W     = $clog2(MAP_WORD_BITS);
  localparam int BLK_W         = 10;
  localparam int BLK_CNT_W     = BLK_W + 1;

  localparam logic [WORD_IDX_W-1:0] LAST_WORD = WORD_IDX_W'(MAP_WORDS - 1);
  localparam logic [BLK_W-1:0]      RESERVED_RESET = BLK_W'(3);

  // command codes
  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef logic [MAP_WORD_BITS-1:0] map_word_t;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [BLK_W-1:0] block_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [BLK_W-1:0] block_number;
    logic             is_free;
  } out_item_t;

  typedef struct packed {
    logic                  rd_en;
    logic [WORD_IDX_W-1:0] rd_addr;
    logic                  wr_en;
    logic [WORD_IDX_W-1:0] wr_addr;
    map_word_t             wr_data;
  } map_req_t;

  // index of the lowest set bit, via isolation of that bit
  function automatic logic [BIT_IDX_W-1:0] lowest_set(input map_word_t w);
    map_word_t             iso;
    logic [BIT_IDX_W-1:0]  idx;
    iso = w & (~w + map_word_t'(1));
    idx = '0;
    for (int i = 0; i < MAP_WORD_BITS; i++) begin
      if (iso[i]) idx = idx | BIT_IDX_W'(i);
    end
    return idx;
  endfunction

  function automatic map_word_t bit_mask(input logic [BIT_IDX_W-1:0] b);
    return map_word_t'(1) << b;
  endfunction

endpackage

// ===== rtl/fbba_map_ram.sv =====
module fbba_map_ram
  import fbba_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  map_req_t  req,
  output map_word_t rd_data
);

  map_word_t                mem [MAP_WORDS];
  logic [MAP_WORDS-1:0]     vld_r;
  map_word_t                mem_q_r;
  logic                     vld_q_r;

  // an unwritten word reads as all free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (req.wr_en) begin
      vld_r[req.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      mem_q_r <= mem[req.rd_addr];
      vld_q_r <= vld_r[req.rd_addr];
    end
  end

  assign rd_data = vld_q_r ? mem_q_r : '1;

endmodule

// ===== rtl/fbba_ctrl.sv =====
module fbba_ctrl
  import fbba_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  in_item_t         in_item,
  input  logic [BLK_W-1:0] reserved,
  output map_req_t         req,
  input  map_word_t        rd_data,
  output logic             out_strobe,
  output out_item_t        out_item
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_CHK  = 3'b100
  } state_t;

  state_t                state_r, state_nxt;
  logic [1:0]            cmd_r, cmd_nxt;
  logic [BLK_W-1:0]      idx_r, idx_nxt;
  logic [WORD_IDX_W-1:0] ptr_r, ptr_nxt;
  logic [WORD_IDX_W-1:0] first_word_r, first_word_nxt;
  logic [BIT_IDX_W-1:0]  first_bit_r, first_bit_nxt;
  logic                  pend_r, pend_nxt;
  logic [WORD_IDX_W-1:0] pend_addr_r, pend_addr_nxt;
  logic                  out_strobe_r, out_strobe_nxt;
  out_item_t             out_item_r, out_item_nxt;

  logic                  accept;
  logic [BLK_CNT_W-1:0]  start_blk;
  logic [BLK_CNT_W-1:0]  in_idx_ext;
  logic                  free_ok, query_ok;
  map_word_t             scan_word;
  logic [BIT_IDX_W-1:0]  hit_bit;
  logic [BIT_IDX_W-1:0]  idx_bit;
  logic [WORD_IDX_W-1:0] idx_word;

  assign busy       = (state_r != S_IDLE);
  assign accept     = start && !busy;
  assign start_blk  = BLK_CNT_W'(reserved) + BLK_CNT_W'(1);
  assign in_idx_ext = BLK_CNT_W'(in_item.block_index);
  assign free_ok    = (in_item.block_index > reserved) &&
                      (in_idx_ext < BLK_CNT_W'(NUM_BLOCKS));
  assign query_ok   = (in_item.block_index != '0) &&
                      (in_idx_ext < BLK_CNT_W'(NUM_BLOCKS));

  assign idx_bit  = idx_r[BIT_IDX_W-1:0];
  assign idx_word = idx_r[BIT_IDX_W +: WORD_IDX_W];

  // candidates in the word back from memory, below the start bit masked off
  assign scan_word = (pend_addr_r == first_word_r) ?
                     (rd_data & ('1 << first_bit_r)) : rd_data;
  assign hit_bit   = lowest_set(scan_word);

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    idx_nxt        = idx_r;
    ptr_nxt        = ptr_r;
    first_word_nxt = first_word_r;
    first_bit_nxt  = first_bit_r;
    pend_nxt       = 1'b0;
    pend_addr_nxt  = pend_addr_r;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = '0;
    req            = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt = in_item.cmd;
          idx_nxt = in_item.block_index;
          case (in_item.cmd)
            CMD_ALLOC: begin
              if (start_blk >= BLK_CNT_W'(NUM_BLOCKS)) begin
                out_strobe_nxt      = 1'b1;
                out_item_nxt.status = ST_FULL;
              end else begin
                ptr_nxt        = start_blk[BIT_IDX_W +: WORD_IDX_W];
                first_word_nxt = start_blk[BIT_IDX_W +: WORD_IDX_W];
                first_bit_nxt  = start_blk[BIT_IDX_W-1:0];
                state_nxt      = S_SCAN;
              end
            end
            CMD_FREE, CMD_QUERY: begin
              if ((in_item.cmd == CMD_FREE) ? free_ok : query_ok) begin
                req.rd_en   = 1'b1;
                req.rd_addr = in_item.block_index[BIT_IDX_W +: WORD_IDX_W];
                state_nxt   = S_CHK;
              end else begin
                out_strobe_nxt      = 1'b1;
                out_item_nxt.status = ST_RANGE;
              end
            end
            default: begin
              out_strobe_nxt      = 1'b1;
              out_item_nxt.status = ST_RANGE;
            end
          endcase
        end
      end

      S_SCAN: begin
        // one word issued per cycle, the previous one evaluated;
        // the last word is read only once
        req.rd_en     = !(pend_r && (pend_addr_r == LAST_WORD));
        req.rd_addr   = ptr_r;
        pend_nxt      = 1'b1;
        pend_addr_nxt = ptr_r;
        if (ptr_r != LAST_WORD) ptr_nxt = ptr_r + WORD_IDX_W'(1);
        if (pend_r) begin
          if (scan_word != '0) begin
            req.wr_en                 = 1'b1;
            req.wr_addr               = pend_addr_r;
            req.wr_data               = rd_data & ~bit_mask(hit_bit);
            out_strobe_nxt            = 1'b1;
            out_item_nxt.status       = ST_OK;
            out_item_nxt.block_number = BLK_W'({pend_addr_r, hit_bit});
            pend_nxt                  = 1'b0;
            state_nxt                 = S_IDLE;
          end else if (pend_addr_r == LAST_WORD) begin
            out_strobe_nxt      = 1'b1;
            out_item_nxt.status = ST_FULL;
            pend_nxt            = 1'b0;
            state_nxt           = S_IDLE;
          end
        end
      end

      S_CHK: begin
        out_strobe_nxt      = 1'b1;
        out_item_nxt.status = ST_OK;
        if (cmd_r == CMD_FREE) begin
          req.wr_en   = 1'b1;
          req.wr_addr = idx_word;
          req.wr_data = rd_data | bit_mask(idx_bit);
        end else begin
          out_item_nxt.is_free = (idx_r > reserved) && rd_data[idx_bit];
        end
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pend_r       <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pend_r       <= pend_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    idx_r        <= idx_nxt;
    ptr_r        <= ptr_nxt;
    first_word_r <= first_word_nxt;
    first_bit_r  <= first_bit_nxt;
    pend_addr_r  <= pend_addr_nxt;
    out_item_r   <= out_item_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

`ifndef ASSERT_OFF
  a_wr_ends_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    req.wr_en |=> (state_r == S_IDLE) && out_strobe_r)
    else $error("map write not followed by a result");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (req.wr_en && req.rd_en) |-> (req.wr_addr != req.rd_addr))
    else $error("read and write of the same map word in one cycle");

  a_chk_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHK) |-> $past(accept))
    else $error("check state reached without an accepted command");

  a_strobe_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> $past(accept || state_r != S_IDLE))
    else $error("result strobe without a command");
`endif

endmodule

// ===== rtl/free_block_bitmap_allocator.sv =====
// first-fit free-block bitmap allocator
// - command channel: present in_item (cmd, block_index) and raise start; the
//   transaction is taken at a clock edge with start high and busy low
// - result channel: out_strobe is high for exactly one cycle with out_item
//   (status, block_number, is_free); the receiver cannot stall it, so it must
//   take every result in that cycle
// - config: cfg_we with cfg_wdata writes reserved_blocks; the user must do
//   so only while idle, and the block itself leaves this unenforced
// - free and query read the map word and answer from the check state; range
//   errors, the unused code and an empty allocation range answer from idle
// - allocate scans the map word by word through the one read port of the map
//   memory, one word a cycle with a registered read, from the word holding
//   reserved_blocks+1 up to the last word
// - a new command is accepted in the cycle its predecessor's result shows
// - reset: reserved_blocks returns to 3 and every block reads as free, using
//   a valid bit per map word, so no clearing pass is needed
module free_block_bitmap_allocator
  import fbba_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  in_item_t         in_item,
  output logic             out_strobe,
  output out_item_t        out_item,
  input  logic             cfg_we,
  input  logic [BLK_W-1:0] cfg_wdata
);

  // reserved region bound; user writes only between transactions, unenforced
  logic [BLK_W-1:0] reserved_r;
  map_req_t         map_req;
  map_word_t        map_rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reserved_r <= RESERVED_RESET;
    end else if (cfg_we) begin
      reserved_r <= cfg_wdata;
    end
  end

  // sequencer: bounds checks, word scan and read-modify-write
  fbba_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .reserved   (reserved_r),
    .req        (map_req),
    .rd_data    (map_rd_data),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  // bitmap storage, one word per entry
  fbba_map_ram u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (map_req),
    .rd_data (map_rd_data)
  );

endmodule

// ===== verif/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import fbba_pkg::*;

  // the command code the block has no use for
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // generous bound: every transaction a full map scan plus the longest idle gap
  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASE_ITEMS = 110;
  localparam int NUM_PHASES  = 8;
  localparam int DRAIN_CYCLES = 40;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  in_item_t         in_item = '0;
  logic             out_strobe;
  out_item_t        out_item;
  logic             cfg_we = 1'b0;
  logic [BLK_W-1:0] cfg_wdata = '0;

  // carried alongside each command: a hand-written answer to use instead of the
  // predicted one
  logic             use_typed = 1'b0;
  out_item_t        typed_answer = '0;

  // own view of the block: one bit per disk block, 1 means free
  bit [NUM_BLOCKS-1:0] blk_free;
  logic [BLK_W-1:0]    reserved;
  out_item_t           pending_answers[$];

  int error_count = 0;
  int cycle_count = 0;

  free_block_bitmap_allocator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // directed opening, run with the reset value of reserved_blocks (3)
  typedef struct {
    in_item_t  cmd_item;
    bit        typed;
    out_item_t want;
  } script_row_t;

  script_row_t script [21] = '{
    '{'{CMD_QUERY,  10'd0},    1'b1, '{ST_RANGE, 10'd0, 1'b0}}, // block zero
    '{'{CMD_QUERY,  10'd1},    1'b1, '{ST_OK,    10'd0, 1'b0}}, // reserved reads as used
    '{'{CMD_QUERY,  10'd3},    1'b1, '{ST_OK,    10'd0, 1'b0}}, // top of reserved region
    '{'{CMD_QUERY,  10'd4},    1'b1, '{ST_OK,    10'd0, 1'b1}}, // first usable block
    '{'{CMD_QUERY,  10'd1023}, 1'b1, '{ST_OK,    10'd0, 1'b1}}, // last block
    '{'{CMD_ALLOC,  10'd1023}, 1'b1, '{ST_OK,    10'd4, 1'b0}}, // index ignored
    '{'{CMD_ALLOC,  10'd0},    1'b1, '{ST_OK,    10'd5, 1'b0}},
    '{'{CMD_QUERY,  10'd4},    1'b1, '{ST_OK,    10'd0, 1'b0}},
    '{'{CMD_FREE,   10'd4},    1'b1, '{ST_OK,    10'd0, 1'b0}},
    '{'{CMD_FREE,   10'd4},    1'b1, '{ST_OK,    10'd0, 1'b0}}, // already free
    '{'{CMD_FREE,   10'd3},    1'b1, '{ST_RANGE, 10'd0, 1'b0}}, // inside reserved region
    '{'{CMD_FREE,   10'd0},    1'b1, '{ST_RANGE, 10'd0, 1'b0}},
    '{'{CMD_FREE,   10'd1023}, 1'b1, '{ST_OK,    10'd0, 1'b0}},
    '{'{CMD_UNUSED, 10'd1023}, 1'b1, '{ST_RANGE, 10'd0, 1'b0}}, // unused code
    '{'{CMD_UNUSED, 10'd0},    1'b1, '{ST_RANGE, 10'd0, 1'b0}},
    '{'{CMD_ALLOC,  10'd0},    1'b1, '{ST_OK,    10'd4, 1'b0}},
    '{'{CMD_ALLOC,  10'h2AA},  1'b0, '0},
    '{'{CMD_FREE,   10'd5},    1'b0, '0},
    '{'{CMD_ALLOC,  10'h155},  1'b0, '0},
    '{'{CMD_QUERY,  10'h2AA},  1'b0, '0},
    '{'{CMD_QUERY,  10'h155},  1'b0, '0}
  };

  task automatic report(input string msg);
    error_count++;
    // keep the log short if things go badly wrong
    if (error_count <= 40) $display("[tb] cycle %0d: %s", cycle_count, msg);
  endtask

  // first-fit answer to one command, updating the free map as the block would
  function automatic out_item_t allocator_answer(input in_item_t c);
    out_item_t r;
    int        b;
    r        = '0;
    r.status = ST_RANGE;
    case (c.cmd)
      CMD_ALLOC: begin
        // lowest free block above the reserved region, or none
        r.status = ST_FULL;
        for (b = int'(reserved) + 1; b < NUM_BLOCKS; b++) begin
          if (blk_free[b]) begin
            blk_free[b]    = 1'b0;
            r.status       = ST_OK;
            r.block_number = BLK_W'(b);
            break;
          end
        end
      end
      CMD_FREE: begin
        // block zero and the reserved region are rejected
        if (c.block_index > reserved) begin
          blk_free[c.block_index] = 1'b1;
          r.status = ST_OK;
        end
      end
      CMD_QUERY: begin
        // reserved blocks read as used whatever their bit says
        if (c.block_index != '0) begin
          r.status  = ST_OK;
          r.is_free = (c.block_index > reserved) && blk_free[c.block_index];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // sample on the edge: results, register writes and accepted transactions
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      blk_free = '1;
      reserved = RESERVED_RESET;
      pending_answers.delete();
    end else begin
      if (out_strobe === 1'b1) begin
        if (pending_answers.size() == 0) begin
          report("result strobe with no transaction outstanding");
        end else begin
          want = pending_answers.pop_front();
          if (out_item.status !== want.status)
            report($sformatf("status got %0d want %0d", out_item.status, want.status));
          if (out_item.block_number !== want.block_number)
            report($sformatf("block_number got %0d want %0d",
                             out_item.block_number, want.block_number));
          if (out_item.is_free !== want.is_free)
            report($sformatf("is_free got %0d want %0d", out_item.is_free, want.is_free));
        end
      end
      if (cfg_we) reserved = cfg_wdata;
      // the map only changes on accepted transactions, and prediction runs only for those
      if (start && !busy) begin
        want = allocator_answer(in_item);
        pending_answers.push_back(use_typed ? typed_answer : want);
      end
    end
  end

  // present one command, after a random idle gap unless calm, and hold it until taken
  task automatic issue(input in_item_t c, input bit typed, input out_item_t w, input bit calm);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(99) < 32) begin
      // mostly short gaps, now and then one as long as a full map scan
      gap = ($urandom_range(7) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 3);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    in_item      <= c;
    use_typed    <= typed;
    typed_answer <= w;
    do @(posedge clk); while (busy);
  endtask

  // lower start and wait for every outstanding transaction to return
  task automatic wait_all_answered();
    start <= 1'b0;
    @(posedge clk);
    while (pending_answers.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  initial begin
    in_item_t         c;
    logic [BLK_W-1:0] setting;
    int               sel;
    int               v;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) issue(script[i].cmd_item, script[i].typed, script[i].want, 1'b0);
    wait_all_answered();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // pick a reserved region size, extremes first
      case (ph)
        0:       setting = '0;
        1:       setting = 10'd1022;
        2:       setting = BLK_W'($urandom_range(960, 1020));
        3:       setting = '1;                 // empty allocation range
        4:       setting = BLK_W'($urandom_range(1023));
        5:       setting = BLK_W'($urandom_range(20));
        6:       setting = RESERVED_RESET;
        default: setting = BLK_W'($urandom_range(1023));
      endcase
      cfg_we    <= 1'b1;
      cfg_wdata <= setting;
      @(posedge clk);
      cfg_we <= 1'b0;
      // let the predictor pick up the new bound before the next command
      @(posedge clk);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        sel   = $urandom_range(99);
        c.cmd = (sel < 42) ? CMD_ALLOC : (sel < 70) ? CMD_FREE :
                (sel < 95) ? CMD_QUERY : CMD_UNUSED;
        // indices cluster round the reserved boundary and the ends of the map
        case ($urandom_range(5))
          0:       v = $urandom_range(1023);
          1, 2:    v = int'(reserved) + $urandom_range(50) - 2;
          3:       v = 1023 - $urandom_range(3);
          4:       v = $urandom_range(4);
          default: v = int'(reserved) + $urandom_range(1);
        endcase
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
        c.block_index = BLK_W'(v);
        // phase five is the long stretch without idling
        issue(c, 1'b0, '0, ph == 5);
      end
      wait_all_answered();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_answers.size() != 0)
      report($sformatf("%0d transactions never answered", pending_answers.size()));

    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/fbba_pkg.sv
rtl/fbba_map_ram.sv
rtl/fbba_ctrl.sv
rtl/free_block_bitmap_allocator.sv
verif/testbench.sv
